[rtl/srt_pkg.sv]
// shared types, widths and codes for the sorted range table
package srt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 512;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int ADDR_W     = 64;
   localparam int PTR_W      = 64;
   localparam int LAST_W     = 32;
   localparam int ACT_W      = 2;
   localparam int STAT_W     = 2;
   localparam int IDX_OUT_W  = 9;
   localparam int IDX_EXT_W  = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

   // beat layout
   localparam int REQ_DATA_W   = 3 * ADDR_W + PTR_W + LAST_W;
   localparam int RSP_FIELDS_W = IDX_OUT_W + ADDR_W + PTR_W + LAST_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // action codes
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS    = 2'd1;
   localparam logic [STAT_W-1:0] ST_PRESENT = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

   // one table entry as stored in the ram
   typedef struct packed {
      logic [LAST_W-1:0] payload_last;
      logic [PTR_W-1:0]  payload_pointer;
      logic [ADDR_W-1:0] range_end;
      logic [ADDR_W-1:0] range_start;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // compare unit flags
   typedef struct packed {
      logic key_lt_start;
      logic key_eq_start;
      logic key_lt_end;
   } cmp_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_HINT_RD,
      S_HINT_CMP,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT,
      S_INS_WR,
      S_RESP
   } state_type;

endpackage

[rtl/sorted_range_table.sv]
// sorted range table: top level with sequencer, entry ram and compare unit
//
// Input channel req_*: one beat per command. req_tuser holds the action
// (clear, insert, lookup); req_tdata holds address, range start, range end
// and the two payload words. Result channel rsp_*: exactly one beat per
// command, status in rsp_tuser, index, start and payload in rsp_tdata.
// Entries live in one ram, kept sorted by start; one 64-bit compare unit
// and the ram's single read port serve every step.
// Clear, a full table and an unused action go straight to the result.
// A lookup first checks the last-hit entry when a hint is held, and
// otherwise, or when the hint misses, runs a binary search in which
// each probe is a ram read, then a compare. An insert searches for its
// slot, then shifts the tail above it up one entry a cycle through the
// ram port and writes the new entry.
// req_tready is high only while idle; the result is held in registers until
// rsp_tready takes it, and the next command is accepted the cycle after.
// Reset empties the table and drops the last-hit hint.
module sorted_range_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // address, range_start, range_end, payload_pointer, payload_last
   input  logic [srt_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [srt_pkg::ACT_W-1:0]      req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // entry_index, found_start, found_payload_pointer, found_payload_last, zero pad
   output logic [srt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [srt_pkg::STAT_W-1:0]     rsp_tuser
);
   import srt_pkg::*;

   // control registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              hint_vld_ff, hint_vld_in;
   logic [IDX_W-1:0]  hint_idx_ff, hint_idx_in;
   logic              rdv_ff, rdv_in;

   // working registers
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   entry_type         new_ff, new_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hix_ff, hix_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic [IDX_W-1:0]  rdlast_ff, rdlast_in;

   // result registers
   logic [STAT_W-1:0] rstat_ff, rstat_in;
   logic [IDX_W-1:0]  ridx_ff, ridx_in;
   logic [ADDR_W-1:0] rstart_ff, rstart_in;
   logic [PTR_W-1:0]  rpp_ff, rpp_in;
   logic [LAST_W-1:0] rpl_ff, rpl_in;

   // ram and compare signals
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type         rd_entry;
   cmp_type           cmp;

   // search helpers
   logic [CNT_W:0]    mid_sum;
   logic [CNT_W-1:0]  mid_c;
   logic [IDX_W-1:0]  mid_idx;
   logic              search_on;
   logic              shift_more;
   logic [CNT_W-1:0]  ptr_dec;
   logic              is_insert;
   logic              hint_hit;
   logic              table_full;
   logic [IDX_EXT_W-1:0] idx_ext;

   assign rd_entry   = entry_type'(rd_data);
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hix_ff} - 1'b1;
   assign mid_c      = mid_sum[CNT_W:1];
   assign mid_idx    = mid_c[IDX_W-1:0];
   assign search_on  = (lo_ff < hix_ff);
   assign shift_more = (ptr_ff > pos_ff);
   assign ptr_dec    = ptr_ff - 1'b1;
   assign is_insert  = (act_ff == ACT_INSERT);
   assign table_full = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign hint_hit   = hint_vld_ff && (CNT_W'(hint_idx_ff) < count_ff)
                       && !cmp.key_lt_start && cmp.key_lt_end;

   // entry storage
   srt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared compare unit
   srt_cmp u_cmp (
      .key         (key_ff),
      .range_start (rd_entry.range_start),
      .range_end   (rd_entry.range_end),
      .flags       (cmp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  ACT_INSERT: state_in = table_full ? S_RESP : S_SRCH_RD;
                  ACT_LOOKUP: state_in = hint_vld_ff ? S_HINT_RD : S_SRCH_RD;
                  default:    state_in = S_RESP;
               endcase
            end
         end
         S_HINT_RD:  state_in = S_HINT_CMP;
         S_HINT_CMP: state_in = hint_hit ? S_RESP : S_SRCH_RD;
         S_SRCH_RD: begin
            if (search_on) begin
               state_in = S_SRCH_CMP;
            end else begin
               state_in = is_insert ? S_SHIFT : S_RESP;
            end
         end
         S_SRCH_CMP: begin
            if (is_insert) begin
               state_in = cmp.key_eq_start ? S_RESP : S_SRCH_RD;
            end else begin
               state_in = (!cmp.key_lt_start && cmp.key_lt_end) ? S_RESP : S_SRCH_RD;
            end
         end
         S_SHIFT: begin
            if (!shift_more && !rdv_ff) begin
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: state_in = S_RESP;
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = (state_ff == S_RESP);
   end

   // datapath and ram control
   always_comb begin
      count_in    = count_ff;
      hint_vld_in = hint_vld_ff;
      hint_idx_in = hint_idx_ff;
      rdv_in      = rdv_ff;
      act_in      = act_ff;
      key_in      = key_ff;
      new_in      = new_ff;
      lo_in       = lo_ff;
      hix_in      = hix_ff;
      pos_in      = pos_ff;
      ptr_in      = ptr_ff;
      mid_in      = mid_ff;
      rdlast_in   = rdlast_ff;
      rstat_in    = rstat_ff;
      ridx_in     = ridx_ff;
      rstart_in   = rstart_ff;
      rpp_in      = rpp_ff;
      rpl_in      = rpl_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_addr     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in                 = req_tuser;
               new_in.range_start     = req_tdata[127:64];
               new_in.range_end       = req_tdata[191:128];
               new_in.payload_pointer = req_tdata[255:192];
               new_in.payload_last    = req_tdata[287:256];
               key_in    = (req_tuser == ACT_INSERT) ? req_tdata[127:64] : req_tdata[63:0];
               lo_in     = '0;
               hix_in    = count_ff;
               pos_in    = count_ff;
               ptr_in    = count_ff;
               rdv_in    = 1'b0;
               ridx_in   = '0;
               rstart_in = '0;
               rpp_in    = '0;
               rpl_in    = '0;
               case (req_tuser)
                  ACT_CLEAR: begin
                     count_in    = '0;
                     hint_vld_in = 1'b0;
                     rstat_in    = ST_OK;
                  end
                  ACT_INSERT: begin
                     hint_vld_in = 1'b0;
                     rstat_in    = ST_FULL;
                  end
                  ACT_LOOKUP: rstat_in = ST_MISS;
                  default:    rstat_in = ST_MISS;
               endcase
            end
         end
         S_HINT_RD: rd_addr = hint_idx_ff;
         S_HINT_CMP: begin
            if (hint_hit) begin
               rstat_in  = ST_OK;
               ridx_in   = hint_idx_ff;
               rstart_in = rd_entry.range_start;
               rpp_in    = rd_entry.payload_pointer;
               rpl_in    = rd_entry.payload_last;
            end else begin
               hint_vld_in = 1'b0;
            end
         end
         S_SRCH_RD: begin
            rd_addr = mid_idx;
            mid_in  = mid_idx;
         end
         S_SRCH_CMP: begin
            if (is_insert) begin
               // insert probe on start only
               if (cmp.key_lt_start) begin
                  pos_in = CNT_W'(mid_ff);
                  hix_in = CNT_W'(mid_ff);
               end else if (cmp.key_eq_start) begin
                  rstat_in = ST_PRESENT;
                  ridx_in  = mid_ff;
               end else begin
                  lo_in = CNT_W'(mid_ff) + 1'b1;
               end
            end else begin
               // lookup probe on start and end
               if (cmp.key_lt_start) begin
                  hix_in = CNT_W'(mid_ff);
               end else if (!cmp.key_lt_end) begin
                  lo_in = CNT_W'(mid_ff) + 1'b1;
               end else begin
                  hint_vld_in = 1'b1;
                  hint_idx_in = mid_ff;
                  rstat_in    = ST_OK;
                  ridx_in     = mid_ff;
                  rstart_in   = rd_entry.range_start;
                  rpp_in      = rd_entry.payload_pointer;
                  rpl_in      = rd_entry.payload_last;
               end
            end
         end
         S_SHIFT: begin
            // move the entry read last cycle up by one slot
            if (rdv_ff) begin
               wr_en   = 1'b1;
               wr_addr = rdlast_ff + 1'b1;
               wr_data = rd_data;
            end
            if (shift_more) begin
               rd_addr   = ptr_dec[IDX_W-1:0];
               rdlast_in = ptr_dec[IDX_W-1:0];
               ptr_in    = ptr_dec;
               rdv_in    = 1'b1;
            end else begin
               rdv_in = 1'b0;
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IDX_W-1:0];
            wr_data  = new_ff;
            count_in = count_ff + 1'b1;
            rstat_in = ST_OK;
            ridx_in  = pos_ff[IDX_W-1:0];
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         hint_vld_ff <= 1'b0;
         hint_idx_ff <= '0;
         rdv_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         hint_vld_ff <= hint_vld_in;
         hint_idx_ff <= hint_idx_in;
         rdv_ff      <= rdv_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      key_ff    <= key_in;
      new_ff    <= new_in;
      lo_ff     <= lo_in;
      hix_ff    <= hix_in;
      pos_ff    <= pos_in;
      ptr_ff    <= ptr_in;
      mid_ff    <= mid_in;
      rdlast_ff <= rdlast_in;
      rstat_ff  <= rstat_in;
      ridx_ff   <= ridx_in;
      rstart_ff <= rstart_in;
      rpp_ff    <= rpp_in;
      rpl_ff    <= rpl_in;
   end

   // result beat
   assign idx_ext   = IDX_EXT_W'(ridx_ff);
   assign rsp_tuser = rstat_ff;
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rpl_ff, rpp_ff, rstart_ff, idx_ext[IDX_OUT_W-1:0]};

   // entry count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // a valid hint always points inside the table
   a_hint_in_table: assert property (@(posedge clock) disable iff (reset)
      hint_vld_ff |-> (CNT_W'(hint_idx_ff) < count_ff))
      else $error("hint index outside filled entries");

   // search window stays ordered and inside the table
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_RD || state_ff == S_SRCH_CMP) |->
         (lo_ff <= hix_ff && hix_ff <= count_ff))
      else $error("search window out of order");

   // clear empties the table and drops the hint
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == ACT_CLEAR) |=>
         (count_ff == '0 && !hint_vld_ff))
      else $error("clear did not empty the table");

   // a successful insert grows the table by one
   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_WR) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the table");

endmodule

[rtl/srt_ram.sv]
// generic single write, single read ram with registered read data
module srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/srt_cmp.sv]
// shared compare unit: search key against one entry's start and end
module srt_cmp (
   input  logic [srt_pkg::ADDR_W-1:0] key,
   input  logic [srt_pkg::ADDR_W-1:0] range_start,
   input  logic [srt_pkg::ADDR_W-1:0] range_end,
   output srt_pkg::cmp_type           flags
);
   import srt_pkg::*;

   // unsigned 64-bit compares
   always_comb begin
      flags              = '0;
      flags.key_lt_start = (key < range_start);
      flags.key_eq_start = (key == range_start);
      flags.key_lt_end   = (key < range_end);
   end

endmodule
